// File: sv/message_packet_segmenter_unit_assert.svh
// Assertion macros for the segmenter RTL.
`ifndef MESSAGE_PACKET_SEGMENTER_UNIT_ASSERT_SVH
`define MESSAGE_PACKET_SEGMENTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPSU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segmenter check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MPSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segmenter check failed one cycle later");

`endif

// File: sv/mps_pkg.sv
package mps_pkg;

  // Default build values.
  localparam int unsigned BYTES_PER_FLIT_DEF   = 64;
  localparam int unsigned FLITS_PER_PACKET_DEF = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF    = 64;

  // Fixed field widths.
  localparam int unsigned ID_W  = 8;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned CNT_W = 8;

  // Numerator width of the constant dividers: a length plus a rounding term.
  localparam int unsigned NUM_W = LEN_W + 1;

  // Divisors below this bound go to the reciprocal divider, which handles them exactly.
  localparam int unsigned DIV_MAX = 65536;

  // Phase codes.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MIDDLE = 2'd1;
  localparam logic [1:0] PH_LAST   = 2'd2;

  typedef struct packed {
    logic [1:0] phase;
    logic       packet_end;
  } ctrl_status_t;

endpackage

// File: sv/mps_cdiv.sv
module mps_cdiv import mps_pkg::*; #(
  parameter int unsigned DIVISOR = 1
) (
  input  logic [NUM_W-1:0] num,
  output logic [NUM_W-1:0] quo
);

  // Exact floor division of an NUM_W-bit value by a constant, done as a
  // multiplication by a rounded-up reciprocal and a shift.
  localparam int unsigned SH_L   = $clog2(DIVISOR);
  localparam int unsigned SHIFT  = NUM_W + SH_L;
  localparam int unsigned MUL_W  = NUM_W + 1;
  localparam int unsigned PROD_W = SHIFT + NUM_W;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [MUL_W-1:0] MULT_C = MUL_W'(MULT);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(num) * PROD_W'(MULT_C);
  assign quo  = prod[SHIFT +: NUM_W];

endmodule

// File: sv/mps_ctrl.sv
module mps_ctrl import mps_pkg::*; #(
  parameter int unsigned BYTES_PER_FLIT   = BYTES_PER_FLIT_DEF,
  parameter int unsigned FLITS_PER_PACKET = FLITS_PER_PACKET_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [LEN_W-1:0] message_bytes,
  output ctrl_status_t     status
);

  localparam int unsigned PK_DIV = BYTES_PER_FLIT * FLITS_PER_PACKET;
  localparam logic [CNT_W-1:0] FPP_C  = CNT_W'(FLITS_PER_PACKET);
  localparam logic [LEN_W-1:0] FPP_L  = LEN_W'(FLITS_PER_PACKET);
  localparam logic [NUM_W-1:0] BPF_N  = NUM_W'(BYTES_PER_FLIT);
  localparam logic [NUM_W-1:0] BPF_M1 = NUM_W'(BYTES_PER_FLIT - 1);

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] fip, fip_next;
  logic [CNT_W-1:0] pidx, pidx_next;
  logic [CNT_W-1:0] full, full_next;
  logic [CNT_W-1:0] pk, pk_next;
  logic [LEN_W-1:0] q1, q1_next;
  logic             sat, sat_next;

  logic [NUM_W-1:0] len_ext, q1_raw, pk_raw;
  logic [LEN_W-1:0] q1_start;
  logic [CNT_W-1:0] full_start, pk_start;
  logic             sat_start;
  logic [NUM_W-1:0] fin_wide;
  logic [CNT_W-1:0] fin;
  logic             starting, pkt_end;
  logic [CNT_W-1:0] cur_fip, cur_pidx, cur_full, cur_pk;
  logic             at_end;

  assign len_ext = NUM_W'(message_bytes);

  // Flit count, rounded up.
  mps_cdiv #(.DIVISOR(BYTES_PER_FLIT)) u_div_flits (
    .num(len_ext + BPF_M1),
    .quo(q1_raw)
  );

  // Packet count, rounded up, straight from the byte length.
  if (PK_DIV < DIV_MAX) begin : g_pk_div
    mps_cdiv #(.DIVISOR(PK_DIV)) u_div_pkts (
      .num(len_ext + NUM_W'(PK_DIV - 1)),
      .quo(pk_raw)
    );
  end else begin : g_pk_one
    assign pk_raw = NUM_W'(message_bytes != '0);
  end

  assign q1_start   = (len_ext < BPF_N) ? LEN_W'(1) : q1_raw[LEN_W-1:0];
  assign full_start = (q1_start < FPP_L) ? q1_start[CNT_W-1:0] : FPP_C;
  assign sat_start  = pk_raw > NUM_W'(255);
  assign pk_start   = (message_bytes == '0) ? CNT_W'(1) :
                      (sat_start ? CNT_W'(255) : pk_raw[CNT_W-1:0]);

  // Size of the final packet, from the stored flit and packet counts.
  assign fin_wide = NUM_W'(q1) - NUM_W'((NUM_W'(pk) - NUM_W'(1)) * NUM_W'(FPP_C));
  assign fin      = sat ? FPP_C : fin_wide[CNT_W-1:0];

  assign starting = (phase != PH_MIDDLE) && (phase != PH_LAST);
  assign cur_fip  = starting ? '0 : fip;
  assign cur_pidx = starting ? '0 : pidx;
  assign cur_full = starting ? full_start : full;
  assign cur_pk   = starting ? pk_start : pk;
  assign at_end   = ({1'b0, cur_fip} + 9'd1) == {1'b0, cur_full};

  always_comb begin
    phase_next = phase;
    fip_next   = fip;
    pidx_next  = pidx;
    full_next  = full;
    pk_next    = pk;
    q1_next    = q1;
    sat_next   = sat;
    pkt_end    = 1'b0;
    unique case (phase)
      PH_LAST: begin
        if (({1'b0, fip} + 9'd1) == {1'b0, fin}) begin
          fip_next   = '0;
          pidx_next  = '0;
          phase_next = PH_IDLE;
          pkt_end    = 1'b1;
        end else begin
          fip_next = fip + CNT_W'(1);
        end
      end
      default: begin
        if (starting) begin
          full_next  = full_start;
          pk_next    = pk_start;
          q1_next    = q1_start;
          sat_next   = sat_start;
          phase_next = PH_MIDDLE;
        end
        pidx_next = cur_pidx;
        fip_next  = cur_fip + CNT_W'(1);
        if (cur_pk >= CNT_W'(2)) begin
          if (at_end && (({1'b0, cur_pidx} + 9'd2) == {1'b0, cur_pk})) begin
            fip_next   = '0;
            pidx_next  = '0;
            phase_next = PH_LAST;
            pkt_end    = 1'b1;
          end else if (at_end) begin
            fip_next  = '0;
            pidx_next = cur_pidx + CNT_W'(1);
            pkt_end   = 1'b1;
          end
        end else if (at_end) begin
          fip_next   = '0;
          phase_next = PH_IDLE;
          pkt_end    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fip   <= '0;
      pidx  <= '0;
      full  <= '0;
      pk    <= '0;
      q1    <= '0;
      sat   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      fip   <= fip_next;
      pidx  <= pidx_next;
      full  <= full_next;
      pk    <= pk_next;
      q1    <= q1_next;
      sat   <= sat_next;
    end
  end

  assign status.phase      = phase;
  assign status.packet_end = pkt_end;

endmodule

// File: sv/mps_out_reg.sv
module mps_out_reg import mps_pkg::*; #(
  parameter int unsigned DATA_W = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] held_data,
  output logic              out_last
);

  // A new item may load when the register is empty or the held one leaves in the same cycle.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
      out_last  <= in_last;
    end
  end

endmodule

// File: sv/message_packet_segmenter_unit.sv
// Channel  Direction  Ports                                  Contents
// -------  ---------  -------------------------------------  ------------------------------
// input    slave      s_tvalid, s_tready, s_tdata            flits with length field
// output   master     m_tvalid, m_tready, m_tdata, m_tlast   same flits, tlast on packet end
//
// One item is accepted every cycle unless the output stalls; an item appears at the
// output in the cycle after it is accepted, through the single output register.
// Reset is synchronous and active high; it returns the block to idle, so the
// next item accepted is taken as the first flit of a message.
// When the output is stalled the held item stays put and s_tready drops;
// it rises in the same cycle the held item is taken.
module message_packet_segmenter_unit import mps_pkg::*; #(
  parameter int unsigned BYTES_PER_FLIT   = BYTES_PER_FLIT_DEF,
  parameter int unsigned FLITS_PER_PACKET = FLITS_PER_PACKET_DEF,
  parameter int unsigned PAYLOAD_WIDTH    = PAYLOAD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // payload, source_id, destination, message_bytes; zero padded to bytes
  input  logic [((PAYLOAD_WIDTH+2*ID_W+LEN_W+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_payload, out_source_id, out_destination, out_message_bytes; zero padded
  output logic [((PAYLOAD_WIDTH+2*ID_W+LEN_W+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);

  localparam int unsigned FIELDS_W = PAYLOAD_WIDTH + 2 * ID_W + LEN_W;
  localparam int unsigned TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int unsigned LEN_LSB  = PAYLOAD_WIDTH + 2 * ID_W;

  logic               accept;
  logic [TDATA_W-1:0] data_in;
  ctrl_status_t       status;

  assign accept = s_tvalid && s_tready;

  // Fields pass straight through; any padding bits are sent as zero.
  assign data_in = TDATA_W'(s_tdata[FIELDS_W-1:0]);

  // Message and packet counters; decide the end flag for each flit.
  mps_ctrl #(
    .BYTES_PER_FLIT  (BYTES_PER_FLIT),
    .FLITS_PER_PACKET(FLITS_PER_PACKET)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .message_bytes(s_tdata[LEN_LSB +: LEN_W]),
    .status       (status)
  );

  // Result register that decouples the two sides.
  mps_out_reg #(
    .DATA_W(TDATA_W)
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (data_in),
    .in_last  (status.packet_end),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .held_data(m_tdata),
    .out_last (m_tlast)
  );

  `include "message_packet_segmenter_unit_assert.svh"

  // Every accepted item shows up at the output in the cycle after.
  `MPSU_ASSERT_NEXT(a_accept_to_out, clk, rst, accept, m_tvalid)

  // The final flit of the last packet always returns the block to idle.
  `MPSU_ASSERT_NEXT(a_last_to_idle, clk, rst, accept && (status.phase == PH_LAST) && status.packet_end, status.phase == PH_IDLE)

  // A flit that ends nothing outside the last packet leaves the block mid-message.
  `MPSU_ASSERT_NEXT(a_stay_middle, clk, rst, accept && (status.phase != PH_LAST) && !status.packet_end, status.phase == PH_MIDDLE)

endmodule
